// ===== src/bpcf_pkg.sv =====
`timescale 1ns / 1ps
package bpcf_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         row_index;
    logic [9:0]         col_index;
    logic [2:0]         point_index;
    logic [3:0]         point_count;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        load_value;
  } in_item_t;

  typedef struct packed {
    logic [47:0] coefficient;
    logic        near_field;
    logic        saturated;
  } out_item_t;

  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_POINT   = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;

  localparam logic CFG_KERNEL_SCALE = 1'b0;
  localparam logic CFG_NEAR_FACTOR  = 1'b1;

  localparam logic [31:0] KERNEL_SCALE_RST = 32'd16777216;
  localparam logic [7:0]  NEAR_FACTOR_RST  = 8'd10;

  // round(pi * 2^32)
  localparam logic [33:0] PI_Q32   = 34'd13493037705;
  localparam logic [47:0] COEF_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_J,
    ST_GOT_J,
    ST_DG_MUL,
    ST_DG_SCALE,
    ST_DG_OUT,
    ST_LIM_SQ,
    ST_LIM_MUL,
    ST_LIM_HOLD,
    ST_DIST,
    ST_NEAR_CHK,
    ST_Q_WAIT,
    ST_Q_GET,
    ST_ROOT_GO,
    ST_SQRT,
    ST_SQRT_END,
    ST_DIV,
    ST_DIV_END,
    ST_NEXT,
    ST_FIN_F,
    ST_FIN_P0,
    ST_FIN_P1,
    ST_FIN_P2,
    ST_FIN_P3,
    ST_FIN_P4,
    ST_FIN_OUT,
    ST_DONE
  } state_t;

endpackage

// ===== src/bem_potential_coeff_fill_core.sv =====
`timescale 1ns / 1ps
// Boundary-element coefficient unit. Header items (mode 0) and quadrature
// point items (mode 1) write the panel table and the point table, with no
// result. A request item (mode 2) returns one Q32.16 coefficient for
// observation panel row_index and source panel col_index: on the diagonal
// 2*sqrt(pi*area)*scale, off the diagonal either area_j*scale/|ci-cj| or,
// when the centers lie closer than near_factor*sqrt(area_i+area_j), the
// weighted quadrature sum over the source panel's points. Items are worked
// one at a time; a finished result waits in the output register while the
// next item is taken. A request whose distance comes out zero skips the
// divide. Requests use the shared square root (one result bit per cycle)
// and the shared restoring divider (one quotient bit per cycle), plus the
// 64x64 final scale product built from four 32x32 partial products on the
// one shared multiplier. No clearing pass after reset: reading a panel or
// point that was never loaded gives an undefined coefficient.
module bem_potential_coeff_fill_core #(
  parameter int MAX_PANELS      = 1024,
  parameter int MAX_QUAD_POINTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpcf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bpcf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import bpcf_pkg::*;

  localparam int PAW   = $clog2(MAX_PANELS);
  localparam int QDEP  = MAX_PANELS * MAX_QUAD_POINTS;
  localparam int QAW   = $clog2(QDEP);
  localparam int CW    = $clog2(MAX_QUAD_POINTS + 1);
  localparam int PEW   = 96 + 32 + CW;

  // configuration
  logic [31:0] ks_r;
  logic [7:0]  nf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r <= KERNEL_SCALE_RST;
      nf_r <= NEAR_FACTOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_SCALE: ks_r <= cfg_wdata;
        CFG_NEAR_FACTOR:  nf_r <= cfg_wdata[7:0];
        default:          ;
      endcase
    end
  end

  state_t state_r, state_nxt;

  logic in_fire;
  assign in_fire = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic          row_ok_c, col_ok_c, pidx_ok_c;
  logic [31:0]   qslot_w_c;
  logic [CW-1:0] cnt_clamp_c;

  always_comb begin
    row_ok_c  = 32'(in_data.row_index) < 32'(MAX_PANELS);
    col_ok_c  = 32'(in_data.col_index) < 32'(MAX_PANELS);
    pidx_ok_c = 32'(in_data.point_index) < 32'(MAX_QUAD_POINTS);
    qslot_w_c = 32'(in_data.row_index) * 32'(MAX_QUAD_POINTS) + 32'(in_data.point_index);
    if (32'(in_data.point_count) > 32'(MAX_QUAD_POINTS)) begin
      cnt_clamp_c = CW'(MAX_QUAD_POINTS);
    end else begin
      cnt_clamp_c = CW'(in_data.point_count);
    end
  end

  // ---------------------------------------------------------------------------
  // Panel and point tables
  // ---------------------------------------------------------------------------
  logic [PEW-1:0] pmem [MAX_PANELS];
  logic [PEW-1:0] pmem_q;
  logic [PAW-1:0] p_raddr_c;
  logic [127:0]   qmem [QDEP];
  logic [127:0]   qmem_q;
  logic [QAW-1:0] q_raddr_c;

  logic [9:0]    col_r;
  logic [CW-1:0] k_r, cnt_r;

  assign q_raddr_c = QAW'(32'(col_r) * 32'(MAX_QUAD_POINTS) + 32'(k_r));

  always_ff @(posedge clk) begin
    if (in_fire && in_data.mode == MODE_HEADER && row_ok_c) begin
      pmem[PAW'(in_data.row_index)] <= {in_data.coord_x, in_data.coord_y, in_data.coord_z,
                                        in_data.load_value, cnt_clamp_c};
    end
    pmem_q <= pmem[p_raddr_c];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.mode == MODE_POINT && row_ok_c && pidx_ok_c) begin
      qmem[QAW'(qslot_w_c)] <= {in_data.coord_x, in_data.coord_y, in_data.coord_z,
                                in_data.load_value};
    end
    qmem_q <= qmem[q_raddr_c];
  end

  // ---------------------------------------------------------------------------
  // Working registers
  // ---------------------------------------------------------------------------
  logic [2:0][31:0] ci_r, op_r;   // observation center, other point
  logic [31:0]      ai_r, aj_r, w_r;
  logic             diag_r, near_r, zero_r, sat_r;
  logic [48:0]      lim_r;        // nf^2 * (ai + aj), before the 2^16 shift
  logic [65:0]      dsq_r;
  logic [1:0]       ds_cnt_r;
  logic [63:0]      acc_r, f_r;
  logic [127:0]     p_r;
  out_item_t        res_r;

  // shared multiplier, product registered
  logic [34:0] mul_a_c, mul_b_c;
  logic [69:0] mul_r;

  always_ff @(posedge clk) begin
    mul_r <= mul_a_c * mul_b_c;
  end

  // one coordinate difference per cycle, magnitude only
  logic signed [33:0] dif_c;
  logic [32:0]        dabs_c;

  always_comb begin
    unique case (ds_cnt_r)
      2'd0:    dif_c = {{2{op_r[2][31]}}, op_r[2]} - {{2{ci_r[2][31]}}, ci_r[2]};
      2'd1:    dif_c = {{2{op_r[1][31]}}, op_r[1]} - {{2{ci_r[1][31]}}, ci_r[1]};
      default: dif_c = {{2{op_r[0][31]}}, op_r[0]} - {{2{ci_r[0][31]}}, ci_r[0]};
    endcase
    if (dif_c[33]) begin
      dabs_c = 33'(-dif_c);
    end else begin
      dabs_c = dif_c[32:0];
    end
  end

  // square root: two radicand bits per step
  logic [69:0] sq_rad_r;
  logic [39:0] sq_rem_r;
  logic [34:0] sq_root_r;
  logic [5:0]  sq_cnt_r;
  logic [39:0] sq_rt_c, sq_tr_c;
  logic        sq_ge_c;

  assign sq_rt_c = {sq_rem_r[37:0], sq_rad_r[69:68]};
  assign sq_tr_c = {3'b000, sq_root_r, 2'b01};
  assign sq_ge_c = sq_rt_c >= sq_tr_c;

  // restoring divider: one quotient bit per step
  logic [63:0] dv_quo_r;
  logic [35:0] dv_rem_r;
  logic [34:0] dv_d_r;
  logic [5:0]  dv_cnt_r;
  logic [35:0] dv_rt_c;
  logic        dv_ge_c;

  assign dv_rt_c = {dv_rem_r[34:0], dv_quo_r[63]};
  assign dv_ge_c = dv_rt_c >= {1'b0, dv_d_r};

  logic [64:0] acc_sum_c;
  logic [32:0] asum_c;
  logic        near_hit_c;

  assign acc_sum_c  = {1'b0, acc_r} + {1'b0, dv_quo_r};
  assign asum_c     = {1'b0, ai_r} + {1'b0, aj_r};
  assign near_hit_c = {1'b0, lim_r, 16'h0000} > dsq_r;

  logic out_valid_r;
  out_item_t out_data_r;
  logic out_free_c;

  assign out_free_c = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.mode == MODE_REQUEST) begin
          state_nxt = (row_ok_c && col_ok_c) ? ST_RD_J : ST_DONE;
        end
      end
      ST_RD_J:     state_nxt = ST_GOT_J;
      ST_GOT_J:    state_nxt = diag_r ? ST_DG_MUL : ST_LIM_SQ;
      ST_DG_MUL:   state_nxt = ST_ROOT_GO;
      ST_DG_SCALE: state_nxt = ST_DG_OUT;
      ST_DG_OUT:   state_nxt = ST_DONE;
      ST_LIM_SQ:   state_nxt = ST_LIM_MUL;
      ST_LIM_MUL:  state_nxt = ST_LIM_HOLD;
      ST_LIM_HOLD: state_nxt = ST_DIST;
      ST_DIST: begin
        if (ds_cnt_r == 2'd3) begin
          state_nxt = near_r ? ST_ROOT_GO : ST_NEAR_CHK;
        end
      end
      ST_NEAR_CHK: begin
        if (near_hit_c) begin
          state_nxt = (cnt_r == '0) ? ST_FIN_F : ST_Q_WAIT;
        end else begin
          state_nxt = ST_ROOT_GO;
        end
      end
      ST_Q_WAIT:   state_nxt = ST_Q_GET;
      ST_Q_GET:    state_nxt = ST_DIST;
      ST_ROOT_GO:  state_nxt = ST_SQRT;
      ST_SQRT:     state_nxt = (sq_cnt_r == 6'd34) ? ST_SQRT_END : ST_SQRT;
      ST_SQRT_END: begin
        priority if (diag_r) begin
          state_nxt = ST_DG_SCALE;
        end else if (sq_root_r == '0) begin
          state_nxt = near_r ? ST_NEXT : ST_FIN_F;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:      state_nxt = (dv_cnt_r == 6'd63) ? ST_DIV_END : ST_DIV;
      ST_DIV_END:  state_nxt = near_r ? ST_NEXT : ST_FIN_F;
      ST_NEXT: begin
        state_nxt = ((32'(k_r) + 32'd1) < 32'(cnt_r)) ? ST_Q_WAIT : ST_FIN_F;
      end
      ST_FIN_F:    state_nxt = ST_FIN_P0;
      ST_FIN_P0:   state_nxt = ST_FIN_P1;
      ST_FIN_P1:   state_nxt = ST_FIN_P2;
      ST_FIN_P2:   state_nxt = ST_FIN_P3;
      ST_FIN_P3:   state_nxt = ST_FIN_P4;
      ST_FIN_P4:   state_nxt = ST_FIN_OUT;
      ST_FIN_OUT:  state_nxt = ST_DONE;
      ST_DONE:     state_nxt = out_free_c ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: stall, table address, multiplier operands
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall  = state_r != ST_IDLE;
    p_raddr_c = (state_r == ST_IDLE) ? PAW'(in_data.row_index) : PAW'(col_r);
    mul_a_c   = '0;
    mul_b_c   = '0;
    unique case (state_r)
      ST_DG_MUL: begin
        mul_a_c = 35'(ai_r);
        mul_b_c = 35'(PI_Q32);
      end
      ST_DG_SCALE: begin
        mul_a_c = sq_root_r;
        mul_b_c = 35'(ks_r);
      end
      ST_LIM_SQ: begin
        mul_a_c = 35'(nf_r);
        mul_b_c = 35'(nf_r);
      end
      ST_LIM_MUL: begin
        mul_a_c = 35'(mul_r[15:0]);
        mul_b_c = 35'(asum_c);
      end
      ST_DIST: begin
        mul_a_c = 35'(dabs_c);
        mul_b_c = 35'(dabs_c);
      end
      ST_FIN_F: begin
        mul_a_c = 35'(aj_r);
        mul_b_c = 35'(ks_r);
      end
      ST_FIN_P0: begin
        mul_a_c = 35'(mul_r[31:0]);
        mul_b_c = 35'(acc_r[31:0]);
      end
      ST_FIN_P1: begin
        mul_a_c = 35'(f_r[31:0]);
        mul_b_c = 35'(acc_r[63:32]);
      end
      ST_FIN_P2: begin
        mul_a_c = 35'(f_r[63:32]);
        mul_b_c = 35'(acc_r[31:0]);
      end
      ST_FIN_P3: begin
        mul_a_c = 35'(f_r[63:32]);
        mul_b_c = 35'(acc_r[63:32]);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free_c) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          col_r  <= in_data.col_index;
          diag_r <= in_data.row_index == in_data.col_index;
          near_r <= 1'b0;
          zero_r <= 1'b0;
          sat_r  <= 1'b0;
          acc_r  <= '0;
          k_r    <= '0;
          res_r  <= '0;   // out-of-range request answers all zero
        end
      end
      ST_RD_J: begin
        ci_r <= {pmem_q[PEW-1 -: 32], pmem_q[PEW-33 -: 32], pmem_q[PEW-65 -: 32]};
        ai_r <= pmem_q[CW+31:CW];
      end
      ST_GOT_J: begin
        op_r  <= {pmem_q[PEW-1 -: 32], pmem_q[PEW-33 -: 32], pmem_q[PEW-65 -: 32]};
        aj_r  <= pmem_q[CW+31:CW];
        cnt_r <= pmem_q[CW-1:0];
      end
      ST_DG_OUT: begin
        res_r.coefficient <= 48'(mul_r[67:31]);
        res_r.near_field  <= 1'b0;
        res_r.saturated   <= 1'b0;
      end
      ST_LIM_HOLD: begin
        lim_r    <= mul_r[48:0];
        ds_cnt_r <= 2'd0;
      end
      ST_DIST: begin
        ds_cnt_r <= ds_cnt_r + 2'd1;
        if (ds_cnt_r == 2'd0) begin
          dsq_r <= '0;
        end else begin
          dsq_r <= dsq_r + mul_r[65:0];
        end
      end
      ST_NEAR_CHK: begin
        if (near_hit_c) begin
          near_r <= 1'b1;
          k_r    <= '0;
        end
      end
      ST_Q_GET: begin
        op_r     <= {qmem_q[127:96], qmem_q[95:64], qmem_q[63:32]};
        w_r      <= qmem_q[31:0];
        ds_cnt_r <= 2'd0;
      end
      ST_ROOT_GO: begin
        sq_rad_r  <= diag_r ? mul_r : {4'b0000, dsq_r};
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        sq_cnt_r  <= '0;
      end
      ST_SQRT: begin
        sq_rad_r  <= {sq_rad_r[67:0], 2'b00};
        sq_rem_r  <= sq_ge_c ? (sq_rt_c - sq_tr_c) : sq_rt_c;
        sq_root_r <= {sq_root_r[33:0], sq_ge_c};
        sq_cnt_r  <= sq_cnt_r + 6'd1;
      end
      ST_SQRT_END: begin
        if (!diag_r) begin
          if (sq_root_r == '0) begin
            zero_r <= 1'b1;
          end
          // near term: weight/d, far term: 1.0/d, both in Q32.32
          dv_quo_r <= near_r ? {w_r, 32'h0} : {32'd65536, 32'h0};
          dv_rem_r <= '0;
          dv_d_r   <= sq_root_r;
          dv_cnt_r <= '0;
        end
      end
      ST_DIV: begin
        dv_rem_r <= dv_ge_c ? (dv_rt_c - {1'b0, dv_d_r}) : dv_rt_c;
        dv_quo_r <= {dv_quo_r[62:0], dv_ge_c};
        dv_cnt_r <= dv_cnt_r + 6'd1;
      end
      ST_DIV_END: begin
        if (!near_r) begin
          acc_r <= dv_quo_r;
        end else if (acc_sum_c[64]) begin
          acc_r <= '1;
          sat_r <= 1'b1;
        end else begin
          acc_r <= acc_sum_c[63:0];
        end
      end
      ST_NEXT: begin
        k_r <= k_r + CW'(1);
      end
      ST_FIN_P0: begin
        f_r <= mul_r[63:0];
      end
      ST_FIN_P1: begin
        p_r <= {64'h0, mul_r[63:0]};
      end
      ST_FIN_P2, ST_FIN_P3: begin
        p_r <= p_r + {32'h0, mul_r[63:0], 32'h0};
      end
      ST_FIN_P4: begin
        p_r <= p_r + {mul_r[63:0], 64'h0};
      end
      ST_FIN_OUT: begin
        res_r.near_field <= near_r;
        priority if (zero_r || p_r[127:104] != '0) begin
          res_r.coefficient <= COEF_MAX;
          res_r.saturated   <= 1'b1;
        end else begin
          res_r.coefficient <= p_r[103:56];
          res_r.saturated   <= sat_r;
        end
      end
      ST_DONE: begin
        if (out_free_c) begin
          out_data_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/tb_bem_potential_coeff_fill_core.sv =====
`timescale 1ns / 1ps
module tb_bem_potential_coeff_fill_core;
  import bpcf_pkg::*;

  localparam int NPANEL = 1024;
  localparam int NSLOT = 8;
  localparam int POOL_N = 12;
  localparam longint CYCLE_LIMIT = 3000000;

  // Shadow copy of the panel tables plus the queue of coefficients still owed.
  class coeff_board;
    logic [95:0] center[NPANEL];
    logic [31:0] area[NPANEL];
    logic [3:0]  npts[NPANEL];
    logic [95:0] qcoord[NPANEL*NSLOT];
    logic [31:0] qweight[NPANEL*NSLOT];
    bit          hdr_set[NPANEL];
    bit          pt_set[NPANEL*NSLOT];
    logic [31:0] kscale;
    logic [7:0]  nfac;
    out_item_t   owed[$];
    int          errors;

    function void init();
      kscale = KERNEL_SCALE_RST;
      nfac = NEAR_FACTOR_RST;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == CFG_KERNEL_SCALE) kscale = val;
      else nfac = val[7:0];
    endfunction

    function logic [63:0] isqrt(logic [127:0] v);
      logic [127:0] r;
      logic [127:0] c;
      r = 0;
      for (int b = 34; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= v) r = c;
      end
      return r[63:0];
    endfunction

    function logic [127:0] dist2(logic [95:0] p, logic [95:0] q);
      logic [127:0] s;
      logic signed [33:0] d;
      logic [127:0] m;
      s = 0;
      for (int c = 0; c < 3; c++) begin
        d = $signed({{2{q[32*c+31]}}, q[32*c +: 32]}) - $signed({{2{p[32*c+31]}}, p[32*c +: 32]});
        if (d < 0) d = -d;
        m = {94'd0, d};
        s = s + m * m;
      end
      return s;
    endfunction

    function bit is_near(int i, int j);
      logic [127:0] lim;
      lim = ({120'd0, nfac} * {120'd0, nfac} * ({96'd0, area[i]} + {96'd0, area[j]})) << 16;
      return dist2(center[i], center[j]) < lim;
    endfunction

    // Coefficient for observation panel i, source panel j.
    function out_item_t coeff(int i, int j);
      out_item_t r;
      logic [127:0] t;
      logic [63:0] acc, nacc, d, q, f;
      bit hit_zero;
      r = '0;
      hit_zero = 0;
      acc = 0;
      if (i == j) begin
        t = {64'd0, isqrt({96'd0, area[i]} * {94'd0, PI_Q32})} * {96'd0, kscale};
        if (t[127:79] != 0) begin
          r.coefficient = COEF_MAX;
          r.saturated = 1;
        end else r.coefficient = t[78:31];
        return r;
      end
      if (is_near(i, j)) begin
        r.near_field = 1;
        for (int k = 0; k < npts[j] && k < NSLOT; k++) begin
          d = isqrt(dist2(center[i], qcoord[j*NSLOT+k]));
          if (d == 0) hit_zero = 1;
          else begin
            q = {qweight[j*NSLOT+k], 32'd0} / d;
            nacc = acc + q;
            if (nacc < acc) begin
              nacc = '1;
              r.saturated = 1;
            end
            acc = nacc;
          end
        end
      end else begin
        d = isqrt(dist2(center[i], center[j]));
        if (d == 0) hit_zero = 1;
        else acc = (64'd1 << 48) / d;
      end
      if (hit_zero) begin
        r.coefficient = COEF_MAX;
        r.saturated = 1;
      end else begin
        f = {32'd0, area[j]} * {32'd0, kscale};
        t = {64'd0, f} * {64'd0, acc};
        if (t[127:104] != 0) begin
          r.coefficient = COEF_MAX;
          r.saturated = 1;
        end else r.coefficient = t[103:56];
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      int s;
      case (it.mode)
        MODE_HEADER: begin
          center[it.row_index] = {it.coord_z, it.coord_y, it.coord_x};
          area[it.row_index] = it.load_value;
          npts[it.row_index] = (it.point_count > NSLOT) ? 4'(NSLOT) : it.point_count;
          hdr_set[it.row_index] = 1;
        end
        MODE_POINT: begin
          s = it.row_index * NSLOT + it.point_index;
          qcoord[s] = {it.coord_z, it.coord_y, it.coord_x};
          qweight[s] = it.load_value;
          pt_set[s] = 1;
        end
        MODE_REQUEST: owed.push_back(coeff(it.row_index, it.col_index));
        default: ;
      endcase
    endfunction

    function void check(out_item_t got);
      out_item_t exp_r;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = owed.pop_front();
      if (got.coefficient !== exp_r.coefficient || got.near_field !== exp_r.near_field ||
          got.saturated !== exp_r.saturated) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected coef %h near %b sat %b, got coef %h near %b sat %b",
                   exp_r.coefficient, exp_r.near_field, exp_r.saturated,
                   got.coefficient, got.near_field, got.saturated);
      end
    endfunction

    // A request must not touch any table entry never loaded.
    function bit readable(int i, int j);
      if (!hdr_set[i] || !hdr_set[j]) return 0;
      if (i == j || !is_near(i, j)) return 1;
      for (int k = 0; k < npts[j]; k++)
        if (!pt_set[j*NSLOT+k]) return 0;
      return 1;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  coeff_board board;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  bit hold_out = 0;
  longint cycles = 0;
  int pool[POOL_N];

  bem_potential_coeff_fill_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Watchdog: anything stuck this long is a hang.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Monitors: accepted items feed the predictor, accepted results get checked.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_input(in_data);
    if (rst_n && out_valid && !out_stall) board.check(out_data);
  end

  // Receiver back-pressure; hold_out forces a long stall.
  always @(negedge clk)
    out_stall <= hold_out || ($urandom_range(99) < out_stall_pct);

  // Offer one item after a random gap and wait until the block takes it.
  task automatic send(in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 0;
  endtask

  // Drain all owed results, then give a trailing load time to settle.
  task automatic drain();
    go_idle();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    board.set_reg(idx, val);
  endtask

  function automatic in_item_t mk(logic [1:0] m, int r, int c, int pi, int pc,
                                  logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic [31:0] v);
    in_item_t it;
    it.mode = m;
    it.row_index = r[9:0];
    it.col_index = c[9:0];
    it.point_index = pi[2:0];
    it.point_count = pc[3:0];
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.load_value = v;
    return it;
  endfunction

  // Coordinates on a coarse grid near the origin so near hits and exact
  // coincidences happen; now and then anywhere in the full range.
  function automatic logic [31:0] rand_coord();
    int u;
    u = $urandom_range(99);
    if (u < 10) return $urandom;
    if (u < 60) return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
    return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
  endfunction

  function automatic logic [31:0] rand_value();
    int u;
    u = $urandom_range(99);
    if (u < 5) return 0;
    if (u < 10) return 32'hFFFF_FFFF;
    if (u < 20) return $urandom;
    return $urandom_range(32'h1000, 32'h40000);
  endfunction

  // Header plus its full set of points, random garbage-free content.
  task automatic load_panel(int p);
    int pc, n;
    pc = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 4 + $urandom_range(4));
    n = (pc > NSLOT) ? NSLOT : pc;
    send(mk(MODE_HEADER, p, $urandom_range(1023), $urandom_range(7), pc,
            rand_coord(), rand_coord(), rand_coord(), rand_value()));
    for (int k = 0; k < n; k++)
      send(mk(MODE_POINT, p, $urandom_range(1023), k, $urandom_range(15),
              rand_coord(), rand_coord(), rand_coord(), rand_value()));
  endtask

  task automatic random_items(int count);
    int sent, u, i, j, tries;
    sent = 0;
    while (sent < count) begin
      u = $urandom_range(99);
      if (u < 20) begin
        load_panel(pool[$urandom_range(POOL_N - 1)]);
      end else if (u < 25) begin
        // noise: unused mode or a stray point load
        if ($urandom_range(1))
          send(mk(2'd3, $urandom_range(1023), $urandom_range(1023), $urandom_range(7),
                  $urandom_range(15), $urandom, $urandom, $urandom, $urandom));
        else
          send(mk(MODE_POINT, pool[$urandom_range(POOL_N - 1)], $urandom_range(1023),
                  $urandom_range(7), $urandom_range(15), rand_coord(), rand_coord(),
                  rand_coord(), rand_value()));
      end else begin
        tries = 0;
        do begin
          i = pool[$urandom_range(POOL_N - 1)];
          j = ($urandom_range(7) == 0) ? i : pool[$urandom_range(POOL_N - 1)];
          tries++;
        end while (!board.readable(i, j) && tries < 20);
        if (board.readable(i, j))
          send(mk(MODE_REQUEST, i, j, $urandom_range(7), $urandom_range(15),
                  $urandom, $urandom, $urandom, $urandom));
        else load_panel(pool[$urandom_range(POOL_N - 1)]);
      end
      sent++;
    end
  endtask

  task automatic directed();
    logic [31:0] one;
    one = 32'h10000;
    send(mk(MODE_HEADER, 0, 0, 0, 2, 0, 0, 0, one));
    send(mk(MODE_POINT, 0, 0, 0, 0, one, 0, 0, one));
    send(mk(MODE_POINT, 0, 0, 1, 0, 0, 2 * one, 0, 32'hFFFF_FFFF));
    // count above the slot limit gets clipped to eight
    send(mk(MODE_HEADER, 1023, 1023, 7, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'hFFFF_FFFF));
    for (int k = 0; k < NSLOT; k++)
      send(mk(MODE_POINT, 1023, 0, k, 0, (k == 7) ? 32'h8000_0000 : 32'h7FFF_0000 + k,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF >> k));
    // same center as panel 0, zero area and no points
    send(mk(MODE_HEADER, 1, 0, 0, 0, 0, 0, 0, 0));
    // nearby panel whose only point sits on panel 0's center, zero weight
    send(mk(MODE_HEADER, 2, 0, 0, 1, 3 * one, 0, 0, one));
    send(mk(MODE_POINT, 2, 0, 0, 0, 0, 0, 0, 0));
    send(mk(2'd3, 1023, 1023, 7, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF));
    send(mk(MODE_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_REQUEST, 1023, 1023, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_REQUEST, 1, 1, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_REQUEST, 0, 1, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_REQUEST, 1, 0, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_REQUEST, 0, 2, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_REQUEST, 0, 1023, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_REQUEST, 1023, 0, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_REQUEST, 2, 0, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    board = new();
    board.init();
    pool[0] = 0;
    pool[1] = 1023;
    pool[2] = 1;
    pool[3] = 2;
    for (int p = 4; p < POOL_N; p++) pool[p] = $urandom_range(3, 1022);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // phase 0: reset settings, no idling
    directed();
    random_items(35);
    drain();

    // phase 1: every off-diagonal pair goes far, largest scale; sender idles often
    write_reg(CFG_KERNEL_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_NEAR_FACTOR, 8'd0);
    in_idle_pct = 54;
    random_items(35);
    // sender waits for every owed result before going on
    go_idle();
    while (board.owed.size() != 0) @(posedge clk);
    random_items(10);
    drain();

    // phase 2: zero scale, widest near zone; receiver stalls often
    write_reg(CFG_KERNEL_SCALE, 32'd0);
    write_reg(CFG_NEAR_FACTOR, 8'd255);
    in_idle_pct = 0;
    out_stall_pct = 54;
    random_items(40);
    drain();

    // phase 3: random scale, random near zone; both sides idle
    write_reg(CFG_KERNEL_SCALE, $urandom);
    write_reg(CFG_NEAR_FACTOR, $urandom_range(1, 40));
    in_idle_pct = 25;
    out_stall_pct = 25;
    random_items(40);
    drain();

    // phase 4: receiver holds off long while requests keep coming
    write_reg(CFG_KERNEL_SCALE, 32'h0100_0000);
    write_reg(CFG_NEAR_FACTOR, 8'd10);
    in_idle_pct = 0;
    out_stall_pct = 0;
    fork
      begin
        hold_out = 1;
        repeat (4000) @(posedge clk);
        hold_out = 0;
      end
      random_items(20);
    join
    random_items(30);
    drain();

    if (board.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
